### rtl/idtfr_pkg.sv
// shared types and codes for the idle timeout frame receiver
// no dependencies

package idtfr_pkg;

  typedef enum logic [1:0] {
    ACT_BYTE    = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_READ    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  localparam logic [15:0] TIMEOUT_RESET = 16'd10;
  localparam int          IDX_CMP_W     = 13;

  typedef struct packed {
    logic       frame_done;
    logic       done_frame;
    logic [7:0] done_length;
    logic [7:0] read_length;
    logic       read_pending;
    logic       receiving;
    logic       read_hit;
  } res_t;

endpackage

### rtl/idtfr_store.sv
// frame byte store: one write port, one registered read port
// no package dependencies

module idtfr_store #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem_r [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/idtfr_ctrl.sv
// frame state: lengths, pending flags, busy, idle count and write frame
// depends on idtfr_pkg

module idtfr_ctrl import idtfr_pkg::*; #(
  parameter int FRAME_COUNT = 2,
  parameter int FRAME_BYTES = 256,
  parameter int FW          = 1,
  parameter int LW          = 8,
  parameter int AW          = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  action_t       action,
  input  logic [7:0]    data_byte,
  input  logic          frame_select,
  input  logic [7:0]    byte_index,
  input  logic [15:0]   timeout,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output res_t          res
);

  logic [LW-1:0] len_r [FRAME_COUNT];
  logic          pend_r [FRAME_COUNT];
  logic          busy_r, busy_nxt;
  logic [15:0]   idle_r, idle_nxt;
  logic [FW-1:0] wframe_r, wframe_nxt;
  logic [LW-1:0] cur_len_r, cur_len_nxt;

  logic [FW-1:0] sel;
  logic [LW-1:0] byte_len, len_inc, sel_len;
  logic [15:0]   idle_inc;
  logic          is_close, is_byte, is_rel, read_hit, sel_pend;

  assign sel      = FW'(frame_select);
  assign byte_len = busy_r ? cur_len_r : '0;
  assign len_inc  = (byte_len >= LW'(FRAME_BYTES - 2)) ? LW'(FRAME_BYTES - 1)
                                                       : byte_len + LW'(1);
  assign idle_inc = (idle_r == 16'hFFFF) ? idle_r : idle_r + 16'd1;
  assign is_byte  = (action == ACT_BYTE);
  assign is_rel   = (action == ACT_RELEASE);
  assign is_close = (action == ACT_TICK) && busy_r && (idle_inc >= timeout);
  assign read_hit = (action == ACT_READ) &&
                    ({5'b0, byte_index} < IDX_CMP_W'(FRAME_BYTES));

  always_comb begin
    busy_nxt    = busy_r;
    idle_nxt    = idle_r;
    wframe_nxt  = wframe_r;
    cur_len_nxt = cur_len_r;
    unique case (action)
      ACT_BYTE: begin
        busy_nxt    = 1'b1;
        idle_nxt    = '0;
        cur_len_nxt = len_inc;
      end
      ACT_TICK: begin
        if (busy_r) begin
          idle_nxt = idle_inc;
        end
        if (is_close) begin
          busy_nxt   = 1'b0;
          wframe_nxt = (wframe_r == FW'(FRAME_COUNT - 1)) ? '0 : wframe_r + FW'(1);
        end
      end
      ACT_READ, ACT_RELEASE: begin
        busy_nxt = busy_r;
      end
      default: begin
        busy_nxt = busy_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      idle_r    <= '0;
      wframe_r  <= '0;
      cur_len_r <= '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        len_r[i]  <= '0;
        pend_r[i] <= 1'b0;
      end
    end else if (accept) begin
      busy_r    <= busy_nxt;
      idle_r    <= idle_nxt;
      wframe_r  <= wframe_nxt;
      cur_len_r <= cur_len_nxt;
      for (int i = 0; i < FRAME_COUNT; i++) begin
        if (is_byte && wframe_r == FW'(i)) begin
          len_r[i] <= len_inc;
        end
        if (is_close && wframe_r == FW'(i)) begin
          pend_r[i] <= 1'b1;
        end else if (is_rel && sel == FW'(i)) begin
          pend_r[i] <= 1'b0;
        end
      end
    end
  end

  // selected frame as seen after this beat
  assign sel_len  = (is_byte && sel == wframe_r) ? len_inc : len_r[sel];
  assign sel_pend = is_rel ? 1'b0 : ((is_close && sel == wframe_r) ? 1'b1 : pend_r[sel]);

  always_comb begin
    res.frame_done   = is_close;
    res.done_frame   = is_close ? wframe_r[0] : 1'b0;
    res.done_length  = is_close ? 8'(cur_len_r) : 8'd0;
    res.read_length  = 8'(sel_len);
    res.read_pending = sel_pend;
    res.receiving    = busy_nxt;
    res.read_hit     = read_hit;
  end

  assign wr_en   = accept && is_byte;
  assign wr_addr = AW'(wframe_r) * AW'(FRAME_BYTES) + AW'(byte_len);
  assign wr_data = data_byte;
  assign rd_en   = accept && read_hit;
  assign rd_addr = AW'(sel) * AW'(FRAME_BYTES) + AW'(byte_index);

endmodule

### rtl/idle_timeout_frame_receiver_unit.sv
// Idle timeout frame receiver: takes one beat per clock while no result waits with out_ready low,
// and returns one result beat for each, held in the single result register and the registered read of the
// byte store (FRAME_COUNT x FRAME_BYTES bytes, no clearing after reset; unwritten bytes read
// undefined). Bytes fill the current frame; timer ticks without bytes close it after
// cfg_wdata ticks (reset 10), mark it pending and move on to the next frame in turn.
// Depends on idtfr_pkg, idtfr_ctrl and idtfr_store.

module idle_timeout_frame_receiver_unit import idtfr_pkg::*; #(
  parameter int FRAME_COUNT = 2,
  parameter int FRAME_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_select,
  input  logic [7:0]  in_byte_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_done,
  output logic        out_done_frame,
  output logic [7:0]  out_done_length,
  output logic [7:0]  out_read_data,
  output logic [7:0]  out_read_length,
  output logic        out_read_pending,
  output logic        out_receiving,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int FW = (FRAME_COUNT > 2) ? $clog2(FRAME_COUNT) : 1;
  localparam int LW = $clog2(FRAME_BYTES);
  localparam int AW = $clog2(FRAME_COUNT * FRAME_BYTES);

  logic [15:0]   timeout_r;
  logic          out_valid_r;
  res_t          res, res_r;
  logic          accept;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0]    wr_data, rd_data;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  idtfr_ctrl #(
    .FRAME_COUNT (FRAME_COUNT),
    .FRAME_BYTES (FRAME_BYTES),
    .FW          (FW),
    .LW          (LW),
    .AW          (AW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .action       (action_t'(in_action)),
    .data_byte    (in_data_byte),
    .frame_select (in_frame_select),
    .byte_index   (in_byte_index),
    .timeout      (timeout_r),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .res          (res)
  );

  idtfr_store #(
    .DEPTH (FRAME_COUNT * FRAME_BYTES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_frame_done   = res_r.frame_done;
  assign out_done_frame   = res_r.done_frame;
  assign out_done_length  = res_r.done_length;
  assign out_read_data    = res_r.read_hit ? rd_data : 8'd0;
  assign out_read_length  = res_r.read_length;
  assign out_read_pending = res_r.read_pending;
  assign out_receiving    = res_r.receiving;

`ifndef SYNTHESIS
  a_close_ends_rx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> !out_receiving)
    else $error("closed frame still receiving");

  a_byte_starts_rx: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_BYTE |=> out_valid && out_receiving && !out_frame_done)
    else $error("byte beat did not leave receiver busy");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action == ACT_RELEASE |=> out_valid && !out_read_pending)
    else $error("released frame still pending");

  a_read_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_action != ACT_READ |=> out_read_data == 8'd0)
    else $error("read data on non-read beat");
`endif

endmodule
